// ===== rtl/bir_pkg.sv =====
`timescale 1ns / 1ps

package bir_pkg;

   localparam logic [8:0] MAX_WIDTH    = 9'd256;
   localparam logic [8:0] MAX_HEIGHT   = 9'd256;
   localparam logic [8:0] MAX_CHANNELS = 9'd4;

   localparam int STORE_DEPTH = 262144;
   localparam int ADDR_W      = 18;
   localparam int PIX_W       = 17;
   localparam int SIZE_W      = 9;
   localparam int COORD_W     = 8;
   localparam int CH_W        = 2;
   localparam int NCH_W       = 3;
   localparam int FRAC_W      = 16;
   localparam int STEP_W      = 24;
   localparam int POS_W       = 32;
   localparam int PLANE_W     = 17;
   localparam int TOTAL_W     = 19;
   localparam int H_W         = 33;
   localparam int V_W         = 49;
   localparam int CSR_IDX_W   = 3;

   localparam logic [PIX_W-1:0] ONE_Q16 = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH    = 3'd0,
      REG_SRC_HEIGHT   = 3'd1,
      REG_DST_WIDTH    = 3'd2,
      REG_DST_HEIGHT   = 3'd3,
      REG_NUM_CHANNELS = 3'd4
   } csr_reg_type;

   // effective geometry, stable whenever setup is not busy
   typedef struct packed {
      logic [SIZE_W-1:0]  sw;
      logic [SIZE_W-1:0]  sh;
      logic [SIZE_W-1:0]  dw;
      logic [SIZE_W-1:0]  dh;
      logic [NCH_W-1:0]   nch;
      logic [PLANE_W-1:0] plane;
      logic [TOTAL_W-1:0] total;
      logic [STEP_W-1:0]  col_step;
      logic [STEP_W-1:0]  row_step;
   } bir_geom_type;

   typedef struct packed {
      logic busy;
      logic restart;
   } bir_ctl_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = 9'd1;
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/bilinear_image_resize.sv =====
`timescale 1ns / 1ps

// load word: taken back to back when no setup is running
// emit word: POS, ROW, R00, R01, R10, R11, H1, V, OUT (waits while rsp is full) to idle
//   (store read port and the shared multiply-accumulate unit are used in sequence)
// register write: size setup, then column and row step division, req_tready low meanwhile
// reset (synchronous, active high) restores default sizes and clears all positions;
// the pixel store is not cleared and holds undefined data until loaded
module bilinear_image_resize import bir_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [16:0] pixel_in
   input  logic                 req_tuser,   // [0] operation
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [16:0] pixel_out
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data
);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POS,
      S_ROW,
      S_R00,
      S_R01,
      S_R10,
      S_R11,
      S_H1,
      S_V,
      S_OUT
   } emit_state_type;

   bir_geom_type geom;
   bir_ctl_type  ctl;

   emit_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   load_pos_ff, load_pos_in;
   logic [COORD_W-1:0]  out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [CH_W-1:0]     out_ch_ff, out_ch_in;
   logic [POS_W-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic [ADDR_W-1:0]   plane_base_ff, plane_base_in;
   logic [COORD_W-1:0]  ix_ff, ix_in, ix1_ff, ix1_in, iy_ff, iy_in;
   logic [FRAC_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [ADDR_W-1:0]   row0_ff, row0_in, row1_ff, row1_in;
   logic [PIX_W-1:0]    p0_ff, p0_in;
   logic [H_W-1:0]      h0_ff, h0_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [PIX_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                mem_en, mem_we;
   logic [ADDR_W-1:0]   mem_addr;
   logic [PIX_W-1:0]    mem_wdata, mem_rdata;
   logic                mac_en;
   logic [H_W-1:0]      mac_base, mac_other;
   logic [FRAC_W-1:0]   mac_weight;
   logic [V_W-1:0]      mac_acc;

   logic                accept;
   logic [PIX_W-1:0]    pix_sat;
   logic [ADDR_W:0]     load_next;
   logic [SIZE_W-1:0]   sw_m1, sh_m1, dw_m1, dh_m1;
   logic [NCH_W-1:0]    nch_m1;
   logic                col_end, row_end, ch_end, col_last;
   logic [COORD_W-1:0]  col_ix;
   logic [FRAC_W-1:0]   col_dx;
   logic [V_W:0]        rounded_sum;
   logic [17:0]         rounded;

   bir_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom),
      .ctl       (ctl)
   );

   bir_store u_store (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   bir_mac u_mac (
      .clock  (clock),
      .en     (mac_en),
      .base   (mac_base),
      .other  (mac_other),
      .weight (mac_weight),
      .acc    (mac_acc)
   );

   assign req_tready = (state_ff == S_IDLE) && !ctl.busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      load_pos_in   = load_pos_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_ch_in     = out_ch_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      plane_base_in = plane_base_ff;
      ix_in         = ix_ff;
      ix1_in        = ix1_ff;
      iy_in         = iy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      row0_in       = row0_ff;
      row1_in       = row1_ff;
      p0_in         = p0_ff;
      h0_in         = h0_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      mem_en     = 1'b0;
      mem_we     = 1'b0;
      mem_addr   = row0_ff + ADDR_W'(ix_ff);
      pix_sat    = (req_tdata[PIX_W-1:0] > ONE_Q16) ? ONE_Q16 : req_tdata[PIX_W-1:0];
      mem_wdata  = pix_sat;
      mac_en     = 1'b0;
      mac_base   = {16'd0, p0_ff};
      mac_other  = {16'd0, mem_rdata};
      mac_weight = dx_ff;

      sw_m1  = geom.sw - 9'd1;
      sh_m1  = geom.sh - 9'd1;
      dw_m1  = geom.dw - 9'd1;
      dh_m1  = geom.dh - 9'd1;
      nch_m1 = geom.nch - 3'd1;

      col_end  = {1'b0, out_col_ff} == dw_m1;
      row_end  = {1'b0, out_row_ff} == dh_m1;
      ch_end   = {1'b0, out_ch_ff} == nch_m1;
      col_last = col_end || (geom.sw == 9'd1);

      load_next = {1'b0, load_pos_ff} + 19'd1;

      col_ix = col_last ? sw_m1[7:0] : sx_ff[23:16];
      col_dx = col_last ? '0 : sx_ff[15:0];

      rounded_sum = {1'b0, mac_acc} + 50'h0_0000_8000_0000;
      rounded     = rounded_sum[49:32];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_EMIT) begin
                  state_in = S_POS;
               end else begin
                  mem_en      = 1'b1;
                  mem_we      = 1'b1;
                  mem_addr    = load_pos_ff;
                  load_pos_in = (load_next >= geom.total) ? '0 : load_next[ADDR_W-1:0];
               end
            end
         end
         S_POS: begin
            // boundary columns and rows fall back to a zero fraction, so the
            // second tap repeats the first and never leaves the image
            ix_in  = col_ix;
            dx_in  = col_dx;
            ix1_in = (col_dx == '0) ? col_ix : col_ix + 8'd1;
            if (row_end) begin
               iy_in = (geom.dh > 9'd1) ? sh_m1[7:0] : '0;
               dy_in = '0;
            end else if (geom.sh == 9'd1) begin
               iy_in = '0;
               dy_in = '0;
            end else begin
               iy_in = sy_ff[23:16];
               dy_in = sy_ff[15:0];
            end
            state_in = S_ROW;
         end
         S_ROW: begin
            row0_in  = plane_base_ff + ADDR_W'(iy_ff * geom.sw);
            state_in = S_R00;
         end
         S_R00: begin
            mem_en   = 1'b1;
            mem_addr = row0_ff + ADDR_W'(ix_ff);
            row1_in  = row0_ff + ((dy_ff != '0) ? ADDR_W'(geom.sw) : '0);
            state_in = S_R01;
         end
         S_R01: begin
            mem_en   = 1'b1;
            mem_addr = row0_ff + ADDR_W'(ix1_ff);
            p0_in    = mem_rdata;
            state_in = S_R10;
         end
         S_R10: begin
            mem_en   = 1'b1;
            mem_addr = row1_ff + ADDR_W'(ix_ff);
            mac_en   = 1'b1;
            state_in = S_R11;
         end
         S_R11: begin
            mem_en   = 1'b1;
            mem_addr = row1_ff + ADDR_W'(ix1_ff);
            p0_in    = mem_rdata;
            h0_in    = mac_acc[H_W-1:0];
            state_in = S_H1;
         end
         S_H1: begin
            mac_en   = 1'b1;
            state_in = S_V;
         end
         S_V: begin
            mac_en     = 1'b1;
            mac_base   = h0_ff;
            mac_other  = mac_acc[H_W-1:0];
            mac_weight = dy_ff;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (rounded > {1'b0, ONE_Q16}) ? ONE_Q16 : rounded[PIX_W-1:0];
               rsp_last_in  = ch_end && row_end && col_end;
               state_in     = S_IDLE;
               if (col_end) begin
                  out_col_in = '0;
                  sx_in      = '0;
                  if (row_end) begin
                     out_row_in = '0;
                     sy_in      = '0;
                     if (ch_end) begin
                        out_ch_in     = '0;
                        plane_base_in = '0;
                     end else begin
                        out_ch_in     = out_ch_ff + 2'd1;
                        plane_base_in = plane_base_ff + ADDR_W'(geom.plane);
                     end
                  end else begin
                     out_row_in = out_row_ff + 8'd1;
                     sy_in      = sy_ff + POS_W'(geom.row_step);
                  end
               end else begin
                  out_col_in = out_col_ff + 8'd1;
                  sx_in      = sx_ff + POS_W'(geom.col_step);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ctl.restart) begin
         load_pos_in   = '0;
         out_col_in    = '0;
         out_row_in    = '0;
         out_ch_in     = '0;
         sx_in         = '0;
         sy_in         = '0;
         plane_base_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      ix_ff       <= ix_in;
      ix1_ff      <= ix1_in;
      iy_ff       <= iy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      row0_ff     <= row0_in;
      row1_ff     <= row1_in;
      p0_ff       <= p0_in;
      h0_ff       <= h0_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         load_pos_ff   <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         out_ch_ff     <= '0;
         sx_ff         <= '0;
         sy_ff         <= '0;
         plane_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_pos_ff   <= load_pos_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         out_ch_ff     <= out_ch_in;
         sx_ff         <= sx_in;
         sy_ff         <= sy_in;
         plane_base_ff <= plane_base_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_load_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      !ctl.busy |-> {1'b0, load_pos_ff} < geom.total)
      else $error("load position beyond source image");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      !ctl.busy |-> {1'b0, out_ch_ff} < geom.nch)
      else $error("emit channel beyond channel count");

   a_out_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished pixel not moved into the output register");

   a_no_load_during_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !(mem_en && mem_we))
      else $error("store written while a pixel is computed");

endmodule

// ===== rtl/bir_store.sv =====
`timescale 1ns / 1ps

module bir_store import bir_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [PIX_W-1:0]  wdata,
   output logic [PIX_W-1:0]  rdata
);

   logic [PIX_W-1:0] mem_ff [STORE_DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bir_mac.sv =====
`timescale 1ns / 1ps

// acc = (base << 16) + weight * (other - base), registered
module bir_mac import bir_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [H_W-1:0]    base,
   input  logic [H_W-1:0]    other,
   input  logic [FRAC_W-1:0] weight,
   output logic [V_W-1:0]    acc
);

   logic signed [H_W:0]   diff;
   logic signed [50:0]    prod;
   logic signed [50:0]    sum;
   logic [V_W-1:0]        acc_in;
   logic [V_W-1:0]        acc_ff;

   always_comb begin
      diff   = $signed({1'b0, other}) - $signed({1'b0, base});
      prod   = 51'($signed({1'b0, weight}) * diff);
      sum    = $signed({2'b00, base, {FRAC_W{1'b0}}}) + prod;
      acc_in = sum[V_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/bir_setup.sv =====
`timescale 1ns / 1ps

module bir_setup import bir_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data,
   output bir_geom_type         geom,
   output bir_ctl_type          ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PLANE,
      S_TOTAL,
      S_COL,
      S_ROW
   } setup_state_type;

   setup_state_type    state_ff, state_in;
   logic [SIZE_W-1:0]  sw_ff, sw_in, sh_ff, sh_in, dw_ff, dw_in, dh_ff, dh_in;
   logic [NCH_W-1:0]   nch_ff, nch_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [STEP_W-1:0]  col_step_ff, col_step_in, row_step_ff, row_step_in;
   logic [STEP_W-1:0]  num_ff, num_in;
   logic [7:0]         rem_ff, rem_in, den_ff, den_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               restart_ff, restart_in;

   logic               write_hit;
   logic [SIZE_W-1:0]  clamped;
   logic [SIZE_W-1:0]  sw_m1, sh_m1, dw_m1, dh_m1;
   logic [8:0]         rem_sh;
   logic [8:0]         rem_sub;
   logic               q_bit;
   logic [STEP_W-1:0]  quo;

   assign csr_ready = 1'b1;

   always_comb begin
      state_in    = state_ff;
      sw_in       = sw_ff;
      sh_in       = sh_ff;
      dw_in       = dw_ff;
      dh_in       = dh_ff;
      nch_in      = nch_ff;
      plane_in    = plane_ff;
      total_in    = total_ff;
      col_step_in = col_step_ff;
      row_step_in = row_step_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      cnt_in      = cnt_ff;
      restart_in  = 1'b0;

      sw_m1 = sw_ff - 9'd1;
      sh_m1 = sh_ff - 9'd1;
      dw_m1 = dw_ff - 9'd1;
      dh_m1 = dh_ff - 9'd1;

      // one restoring divide step per cycle
      rem_sh  = {rem_ff, num_ff[STEP_W-1]};
      q_bit   = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      quo     = {num_ff[STEP_W-2:0], q_bit};

      unique case (state_ff)
         S_IDLE: begin
         end
         S_PLANE: begin
            plane_in = PLANE_W'(sw_ff * sh_ff);
            state_in = S_TOTAL;
         end
         S_TOTAL: begin
            total_in = TOTAL_W'(plane_ff * nch_ff);
            num_in   = {sw_m1[7:0], {FRAC_W{1'b0}}};
            den_in   = dw_m1[7:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_COL;
         end
         S_COL, S_ROW: begin
            num_in = quo;
            rem_in = q_bit ? rem_sub[7:0] : rem_sh[7:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(STEP_W - 1)) begin
               if (state_ff == S_COL) begin
                  // a single destination column means a step of zero
                  col_step_in = (dw_ff <= 9'd1) ? '0 : quo;
                  num_in      = {sh_m1[7:0], {FRAC_W{1'b0}}};
                  den_in      = dh_m1[7:0];
                  rem_in      = '0;
                  cnt_in      = '0;
                  state_in    = S_ROW;
               end else begin
                  row_step_in = (dh_ff <= 9'd1) ? '0 : quo;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      write_hit = csr_valid;
      clamped   = '0;
      unique case (csr_index)
         REG_SRC_WIDTH: begin
            sw_in = clamp_size(csr_data, MAX_WIDTH);
         end
         REG_SRC_HEIGHT: begin
            sh_in = clamp_size(csr_data, MAX_HEIGHT);
         end
         REG_DST_WIDTH: begin
            dw_in = clamp_size(csr_data, MAX_WIDTH);
         end
         REG_DST_HEIGHT: begin
            dh_in = clamp_size(csr_data, MAX_HEIGHT);
         end
         REG_NUM_CHANNELS: begin
            clamped = clamp_size({6'd0, csr_data[NCH_W-1:0]}, MAX_CHANNELS);
            nch_in  = clamped[NCH_W-1:0];
         end
         default: begin
            write_hit = 1'b0;
         end
      endcase

      if (!write_hit) begin
         sw_in  = sw_ff;
         sh_in  = sh_ff;
         dw_in  = dw_ff;
         dh_in  = dh_ff;
         nch_in = nch_ff;
      end else begin
         restart_in = 1'b1;
         state_in   = S_PLANE;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff    <= S_IDLE;
         sw_ff       <= 9'd1;
         sh_ff       <= 9'd1;
         dw_ff       <= 9'd1;
         dh_ff       <= 9'd1;
         nch_ff      <= 3'd3;
         plane_ff    <= 17'd1;
         total_ff    <= 19'd3;
         col_step_ff <= '0;
         row_step_ff <= '0;
         restart_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sw_ff       <= sw_in;
         sh_ff       <= sh_in;
         dw_ff       <= dw_in;
         dh_ff       <= dh_in;
         nch_ff      <= nch_in;
         plane_ff    <= plane_in;
         total_ff    <= total_in;
         col_step_ff <= col_step_in;
         row_step_ff <= row_step_in;
         restart_ff  <= restart_in;
      end
   end

   always_comb begin
      geom.sw       = sw_ff;
      geom.sh       = sh_ff;
      geom.dw       = dw_ff;
      geom.dh       = dh_ff;
      geom.nch      = nch_ff;
      geom.plane    = plane_ff;
      geom.total    = total_ff;
      geom.col_step = col_step_ff;
      geom.row_step = row_step_ff;
      ctl.busy      = state_ff != S_IDLE;
      ctl.restart   = restart_ff;
   end

   a_write_starts_setup: assert property (@(posedge clock) disable iff (reset)
      write_hit |=> ctl.busy)
      else $error("register write did not start the setup sequence");

   a_restart_while_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.restart |-> state_ff == S_PLANE)
      else $error("restart pulse outside the setup sequence");

   a_sizes_consistent: assert property (@(posedge clock) disable iff (reset)
      !ctl.busy |-> (plane_ff == PLANE_W'(sw_ff * sh_ff)) &&
                    (total_ff == TOTAL_W'(plane_ff * nch_ff)))
      else $error("plane or total size stale after setup");

endmodule

// ===== verif/bilinear_image_resize_test.sv =====
`timescale 1ns / 1ps

module bilinear_image_resize_test;
   import bir_pkg::*;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   localparam int ITEM_TARGET    = 1700;
   localparam int SETTLE_CYCLES  = 16;
   localparam int DRAIN_LIMIT    = 200000;
   localparam int RUN_LIMIT_NS   = 2000000;
   localparam int SINK_HOLD_LONG = 300;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } resized_pixel_t;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;   // [16:0] pixel_in
   logic                 req_tuser;   // [0] operation
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;   // [16:0] pixel_out
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_data;

   // resizer image of the block
   logic [PIX_W-1:0]  src_pixels [STORE_DEPTH];
   logic [SIZE_W-1:0] reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
   logic [NCH_W-1:0]  reg_planes;
   logic [STEP_W-1:0] col_step, row_step;
   int unsigned       load_ptr, col_pos, row_pos, plane_pos;

   resized_pixel_t expected_pixels [$];
   int unsigned    items_sent;
   int unsigned    pixels_checked;
   int unsigned    geometries;
   int unsigned    fail_count;
   int unsigned    sink_hold;
   bit             no_idle;

   bilinear_image_resize u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- resizer model

   function automatic int unsigned fit_size(input int unsigned raw, input int unsigned limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   function automatic int unsigned src_cols();
      return fit_size(reg_src_w, 256);
   endfunction

   function automatic int unsigned src_rows();
      return fit_size(reg_src_h, 256);
   endfunction

   function automatic int unsigned dst_cols();
      return fit_size(reg_dst_w, 256);
   endfunction

   function automatic int unsigned dst_rows();
      return fit_size(reg_dst_h, 256);
   endfunction

   function automatic int unsigned plane_count();
      return fit_size(reg_planes, 4);
   endfunction

   function automatic logic [STEP_W-1:0] span_step(input int unsigned src, input int unsigned dst);
      logic [63:0] q;
      if (dst <= 1) return '0;
      q = (64'(src - 1) << 16) / 64'(dst - 1);
      return q[STEP_W-1:0];
   endfunction

   function automatic void restart_geometry();
      col_step  = span_step(src_cols(), dst_cols());
      row_step  = span_step(src_rows(), dst_rows());
      load_ptr  = 0;
      col_pos   = 0;
      row_pos   = 0;
      plane_pos = 0;
   endfunction

   function automatic void reset_resizer();
      reg_src_w  = 9'd1;
      reg_src_h  = 9'd1;
      reg_dst_w  = 9'd1;
      reg_dst_h  = 9'd1;
      reg_planes = 3'd3;
      restart_geometry();
   endfunction

   function automatic void apply_register(input csr_reg_type idx, input logic [SIZE_W-1:0] value);
      case (idx)
         REG_SRC_WIDTH:    reg_src_w = value;
         REG_SRC_HEIGHT:   reg_src_h = value;
         REG_DST_WIDTH:    reg_dst_w = value;
         REG_DST_HEIGHT:   reg_dst_h = value;
         REG_NUM_CHANNELS: reg_planes = value[NCH_W-1:0];
         default: ;
      endcase
      restart_geometry();
   endfunction

   function automatic void store_source_pixel(input logic [PIX_W-1:0] pix);
      int unsigned total;
      total = src_cols() * src_rows() * plane_count();
      src_pixels[load_ptr] = (pix > ONE_Q16) ? ONE_Q16 : pix;
      load_ptr++;
      if (load_ptr >= total) load_ptr = 0;
   endfunction

   function automatic logic [63:0] src_at(input int unsigned plane, input int unsigned y,
                                          input int unsigned x);
      return 64'(src_pixels[(plane * src_rows() + y) * src_cols() + x]);
   endfunction

   // horizontal blend of one source row at the current column, Q1.32
   function automatic logic [H_W-1:0] row_blend(input int unsigned plane, input int unsigned y);
      logic [63:0] sx, dx, acc;
      int unsigned ix;
      if (col_pos == dst_cols() - 1 || src_cols() == 1) begin
         acc = src_at(plane, y, src_cols() - 1) << 16;
      end else begin
         sx  = 64'(col_pos) * 64'(col_step);
         ix  = int'(sx >> 16);
         dx  = sx & 64'hFFFF;
         acc = (64'd65536 - dx) * src_at(plane, y, ix) + dx * src_at(plane, y, ix + 1);
      end
      return acc[H_W-1:0];
   endfunction

   function automatic resized_pixel_t resize_next_pixel();
      resized_pixel_t res;
      logic [63:0] v, sy, dy, r;
      int unsigned iy;
      if (row_pos == dst_rows() - 1) begin
         v = 64'(row_blend(plane_pos, (dst_rows() > 1) ? src_rows() - 1 : 0)) << 16;
      end else if (src_rows() == 1) begin
         v = 64'(row_blend(plane_pos, 0)) << 16;
      end else begin
         sy = 64'(row_pos) * 64'(row_step);
         iy = int'(sy >> 16);
         dy = sy & 64'hFFFF;
         v  = (64'd65536 - dy) * 64'(row_blend(plane_pos, iy))
            + dy * 64'(row_blend(plane_pos, iy + 1));
      end
      r = (v + 64'h8000_0000) >> 32;
      if (r > 64'd65536) r = 64'd65536;
      res.pixel = r[PIX_W-1:0];
      res.last  = (plane_pos == plane_count() - 1 && row_pos == dst_rows() - 1 &&
                   col_pos == dst_cols() - 1);
      col_pos++;
      if (col_pos >= dst_cols()) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= dst_rows()) begin
            row_pos = 0;
            plane_pos++;
            if (plane_pos >= plane_count()) plane_pos = 0;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int idle_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ONE_Q16;
         2:       return PIX_W'($urandom_range(65537, 131071));
         default: return PIX_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic send_request(input logic op, input logic [PIX_W-1:0] pix);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(24 - PIX_W){1'b0}}, pix};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == OP_LOAD) begin
         store_source_pixel(pix);
      end else begin
         expected_pixels.push_back(resize_next_pixel());
      end
   endtask

   // sender stops until every result is back, then lets loads settle
   task automatic go_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
   endtask

   task automatic configure(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                            input logic [SIZE_W-1:0] dw, input logic [SIZE_W-1:0] dh,
                            input logic [SIZE_W-1:0] planes);
      go_idle();
      write_reg(REG_SRC_WIDTH, sw);
      write_reg(REG_SRC_HEIGHT, sh);
      write_reg(REG_DST_WIDTH, dw);
      write_reg(REG_DST_HEIGHT, dh);
      write_reg(REG_NUM_CHANNELS, planes);
      csr_valid <= 1'b0;
      geometries++;
   endtask

   task automatic load_image();
      repeat (src_cols() * src_rows() * plane_count()) send_request(OP_LOAD, pick_pixel());
   endtask

   // emits with stray loads mixed in, which overwrite already loaded pixels
   task automatic emit_pixels(input int unsigned count);
      while (count > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(OP_LOAD, pick_pixel());
         end else begin
            send_request(OP_EMIT, PIX_W'($urandom_range(0, 131071)));
            count--;
         end
      end
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                            input logic [SIZE_W-1:0] dw, input logic [SIZE_W-1:0] dh,
                            input logic [SIZE_W-1:0] planes, input int unsigned frames,
                            input int unsigned extra);
      configure(sw, sh, dw, dh, planes);
      load_image();
      emit_pixels(frames * dst_cols() * dst_rows() * plane_count() + extra);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      // one pixel per plane, three planes; the top value saturates
      send_request(OP_LOAD, 17'd0);
      send_request(OP_LOAD, ONE_Q16);
      send_request(OP_LOAD, 17'h1FFFF);
      repeat (4) send_request(OP_EMIT, 17'h1FFFF);
   endtask

   task automatic test_upscale_directed();
      configure(9'd2, 9'd2, 9'd3, 9'd3, 9'd1);
      send_request(OP_LOAD, ONE_Q16);
      send_request(OP_LOAD, 17'd0);
      send_request(OP_LOAD, 17'd0);
      send_request(OP_LOAD, 17'h1FFFF);
      // load wraps back onto the first pixel
      send_request(OP_LOAD, 17'd32768);
      repeat (9) send_request(OP_EMIT, 17'd0);
   endtask

   task automatic test_backpressure();
      configure(9'd4, 9'd3, 9'd7, 9'd5, 9'd2);
      load_image();
      no_idle   = 1'b1;
      sink_hold = SINK_HOLD_LONG;
      emit_pixels(40);
      no_idle = 1'b0;
      go_idle();
      emit_pixels(30);
   endtask

   task automatic test_edge_geometries();
      run_phase(9'd5, 9'd4, 9'd3, 9'd2, 9'd1, 2, 0);
      run_phase(9'd1, 9'd4, 9'd5, 9'd6, 9'd1, 1, 0);
      run_phase(9'd6, 9'd1, 9'd9, 9'd4, 9'd1, 1, 0);
      run_phase(9'd5, 9'd5, 9'd1, 9'd4, 9'd1, 2, 0);
      run_phase(9'd5, 9'd5, 9'd4, 9'd1, 9'd2, 2, 0);
      no_idle = 1'b1;
      run_phase(9'd3, 9'd3, 9'd3, 9'd3, 9'd3, 1, 3);
      no_idle = 1'b0;
      run_phase(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 3, 0);
      run_phase(9'd2, 9'd2, 9'd3, 9'd2, 9'd7, 1, 0);
      run_phase(9'd1, 9'd1, 9'd4, 9'd3, 9'h102, 1, 0);
   endtask

   task automatic test_extreme_sizes();
      run_phase(9'd511, 9'd1, 9'd37, 9'd1, 9'd1, 2, 0);
      run_phase(9'd2, 9'd1, 9'd256, 9'd1, 9'd1, 1, 0);
      run_phase(9'd1, 9'd256, 9'd2, 9'd9, 9'd1, 1, 0);
      run_phase(9'd1, 9'd2, 9'd1, 9'd300, 9'd1, 1, 0);
   endtask

   task automatic test_random_geometries();
      while (items_sent < ITEM_TARGET) begin
         run_phase(SIZE_W'($urandom_range(1, 6)), SIZE_W'($urandom_range(1, 6)),
                   SIZE_W'($urandom_range(1, 6)), SIZE_W'($urandom_range(1, 6)),
                   SIZE_W'($urandom_range(1, 4)), 1, $urandom_range(0, 20));
      end
   endtask

   // ---------------------------------------------------------------- result side

   initial begin : result_sink
      int gap;
      gap = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold > 0) begin
            rsp_tready <= 1'b0;
            sink_hold--;
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            gap--;
         end else begin
            rsp_tready <= 1'b1;
            gap = idle_gap();
         end
      end
   end

   always @(posedge clock) begin : result_check
      resized_pixel_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("result word with no pixel pending: pixel_out %0d last_pixel %0b",
                   rsp_tdata[PIX_W-1:0], rsp_tlast);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_tdata[PIX_W-1:0] !== want.pixel) begin
               $error("pixel_out mismatch: expected %0d actual %0d",
                      want.pixel, rsp_tdata[PIX_W-1:0]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_pixel mismatch: expected %0b actual %0b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : main
      int waited;
      items_sent     = 0;
      pixels_checked = 0;
      geometries     = 0;
      fail_count     = 0;
      sink_hold      = 0;
      no_idle        = 1'b0;
      reset_resizer();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_LOAD;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_SRC_WIDTH;
      csr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_upscale_directed();
      test_backpressure();
      test_edge_geometries();
      test_extreme_sizes();
      test_random_geometries();

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixels never came out", expected_pixels.size());
         fail_count++;
      end

      $display("covered %0d request words over %0d geometries, %0d pixels checked",
               items_sent, geometries + 1, pixels_checked);
      $display("sizes from one pixel up to 256 wide and tall, one to four planes");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
